@@ src/sos_surface_monte_carlo_step_macros.svh @@
// ----------------------------------------------------------------------------
// SOS Monte Carlo step - assertion macros
// Concurrent assertion wrappers clocked on clk, disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef SOS_SURFACE_MONTE_CARLO_STEP_MACROS_SVH
`define SOS_SURFACE_MONTE_CARLO_STEP_MACROS_SVH

`ifndef SYNTH
`define SOS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SOS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SOS_ASSERT(lbl, prop, msg)
`define SOS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/sos_pkg.sv @@
// ----------------------------------------------------------------------------
// SOS Monte Carlo step - package
// Sizes, codes and types shared by the channels and the step engine.
// ----------------------------------------------------------------------------
package sos_pkg;

	localparam int SITES         = 128;
	localparam int SITE_W        = $clog2(SITES);
	localparam int MAX_PARTICLES = 8192;
	localparam int PICK_W        = $clog2(MAX_PARTICLES);
	localparam int COUNT_W       = PICK_W + 1;
	localparam int HEIGHT_BITS   = 6;
	localparam int ENERGY_W      = 13;
	localparam int PROB_W        = 16;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_IDX_W     = 1;

	localparam logic [HEIGHT_BITS-1:0] HEIGHT_CAP       = '1;
	localparam logic [PROB_W-1:0]      THRESHOLD_RESET  = PROB_W'(32768);
	localparam logic [HEIGHT_BITS-1:0] MAX_HEIGHT_RESET = HEIGHT_BITS'(50);

	typedef enum logic [1:0] {
		REQ_PLACE   = 2'd0,
		REQ_CREATE  = 2'd1,
		REQ_DESTROY = 2'd2,
		REQ_BAD     = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		STAT_ACCEPTED = 2'd0,
		STAT_BOUND    = 2'd1,
		STAT_DRAW     = 2'd2,
		STAT_INVALID  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACCEPT_THRESHOLD = 1'd0,
		CFG_MAX_HEIGHT       = 1'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PRD,
		S_HC,
		S_HM,
		S_HP,
		S_DEC,
		S_SHIFT,
		S_FIN
	} state_t;

endpackage

@@ src/sos_if.sv @@
// ----------------------------------------------------------------------------
// SOS Monte Carlo step - channel interfaces
// Valid/ready request and response channels with source and sink modports.
// ----------------------------------------------------------------------------
interface sos_req_if;
	logic                           valid;
	logic                           ready;
	sos_pkg::req_type_t             req_type;
	logic [sos_pkg::SITE_W-1:0]     site;
	logic [sos_pkg::PICK_W-1:0]     pick;
	logic [sos_pkg::PROB_W-1:0]     random_draw;

	modport source (output valid, req_type, site, pick, random_draw, input ready);
	modport sink   (input valid, req_type, site, pick, random_draw, output ready);
endinterface

interface sos_rsp_if;
	logic                           valid;
	logic                           ready;
	sos_pkg::status_t               status;
	logic [sos_pkg::SITE_W-1:0]     acted_site;
	logic [sos_pkg::ENERGY_W-1:0]   energy;
	logic [sos_pkg::PICK_W-1:0]     particle_count;

	modport source (output valid, status, acted_site, energy, particle_count, input ready);
	modport sink   (input valid, status, acted_site, energy, particle_count, output ready);
endinterface

@@ src/sos_surface_monte_carlo_step.sv @@
// ----------------------------------------------------------------------------
// SOS Monte Carlo step - top level
// Metropolis place/create/destroy step on a periodic 1-D SOS surface.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one request per handshake (req_type, site, pick, random_draw).
//   rsp  : one response per request (status, acted_site, energy,
//          particle_count), in request order.
//   cfg  : cfg_we/cfg_index/cfg_wdata write accept_threshold (index 0) and
//          max_height (index 1); write only while no request is in flight.
// Sequence:
//   Place or create: three reads of the height RAM (the site, then its left
//   and right neighbors), a decide state and an output load that sets valid.
//   Destroy: a particle list read at pick comes first; an accepted one adds
//   the order-preserving erase, one list entry per cycle through the
//   particle RAM. Bad request or pick: straight to the output load.
//   One request is worked on at a time; a new request is taken while the
//   previous response still sits in the output register.
// Reset: heights read as zero (per-column valid bits), count and energy are
//   zero, registers take their reset values; no clearing pass.
// Stall: a finished response waits in the output register; the engine holds
//   in its final state until that register is free.
// ----------------------------------------------------------------------------
module sos_surface_monte_carlo_step (
	input  logic                               clk,
	input  logic                               arst_n,
	sos_req_if.sink                            req,
	sos_rsp_if.source                          rsp,
	input  logic                               cfg_we,
	input  logic [sos_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sos_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	`include "sos_surface_monte_carlo_step_macros.svh"

	localparam int SW = sos_pkg::SITE_W;
	localparam int PW = sos_pkg::PICK_W;
	localparam int CW = sos_pkg::COUNT_W;
	localparam int HB = sos_pkg::HEIGHT_BITS;
	localparam int EW = sos_pkg::ENERGY_W;
	localparam int RW = sos_pkg::PROB_W;

	sos_pkg::state_t state_q, state_d;

	// configuration
	logic [RW-1:0] thr_q;
	logic [HB-1:0] maxh_q;

	// architectural state
	logic [CW-1:0]            count_q;
	logic [EW-1:0]            en_q;
	logic [sos_pkg::SITES-1:0] hv_q;

	// memories
	logic [HB-1:0] heights_mem [sos_pkg::SITES];
	logic [SW-1:0] plist_mem   [sos_pkg::MAX_PARTICLES];

	logic [HB-1:0] h_rdata_s1;
	logic          hval_s1;
	logic [SW-1:0] plist_rdata_s1;

	// request context
	sos_pkg::req_type_t req_q;
	logic [SW-1:0]      col_q;
	logic [PW-1:0]      pick_q;
	logic [RW-1:0]      draw_q;
	logic [HB-1:0]      h_q;
	logic [HB-1:0]      hm_q;
	sos_pkg::status_t   res_status_q;

	// erase pipeline
	logic [CW-1:0] shift_rd_q;
	logic          sh_s1;
	logic [PW-1:0] sh_addr_s1;

	// output register
	logic               out_valid_q;
	sos_pkg::status_t   out_status_q;
	logic [SW-1:0]      out_site_q;
	logic [EW-1:0]      out_energy_q;
	logic [PW-1:0]      out_count_q;

	logic               accept;
	logic               pick_ok;
	logic               out_load;
	logic [SW-1:0]      cur_col;
	logic [SW-1:0]      col_m;
	logic [SW-1:0]      col_p;
	logic [SW-1:0]      h_raddr;
	logic [HB-1:0]      hcur;
	logic               inc;
	logic [HB-1:0]      limit;
	logic               bound;
	logic               up_m;
	logic               up_p;
	logic               rise;
	logic               fall;
	logic               draw_fail;
	sos_pkg::status_t   dec_status;
	logic               commit;
	logic [HB-1:0]      h_new;
	logic [EW-1:0]      en_next;
	logic               shift_more;
	logic               shift_done;
	logic               p_we;
	logic [PW-1:0]      p_waddr;
	logic [SW-1:0]      p_wdata;
	logic [PW-1:0]      p_raddr;

	assign req.ready  = (state_q == sos_pkg::S_IDLE);
	assign accept     = req.valid && req.ready;
	assign pick_ok    = {1'b0, req.pick} < count_q;

	assign cur_col = (req_q == sos_pkg::REQ_DESTROY) ? plist_rdata_s1 : col_q;
	assign col_m   = (col_q == '0) ? SW'(sos_pkg::SITES - 1) : col_q - 1'b1;
	assign col_p   = (col_q == SW'(sos_pkg::SITES - 1)) ? '0 : col_q + 1'b1;
	assign hcur    = hval_s1 ? h_rdata_s1 : '0;

	always_comb begin
		case (state_q)
			sos_pkg::S_HC: h_raddr = cur_col;
			sos_pkg::S_HM: h_raddr = col_m;
			sos_pkg::S_HP: h_raddr = col_p;
			default:       h_raddr = col_q;
		endcase
	end

	// decision, valid in S_DEC (hcur holds the right neighbor)
	assign inc   = (req_q != sos_pkg::REQ_DESTROY);
	assign limit = (req_q == sos_pkg::REQ_CREATE && maxh_q < sos_pkg::HEIGHT_CAP) ?
		maxh_q : sos_pkg::HEIGHT_CAP;
	assign bound = inc ?
		((count_q >= CW'(sos_pkg::MAX_PARTICLES)) ||
		 ((HB+1)'(h_q) + 1'b1 > (HB+1)'(limit))) :
		(h_q == '0);
	assign up_m      = inc ? (h_q >= hm_q) : (h_q <= hm_q);
	assign up_p      = inc ? (h_q >= hcur) : (h_q <= hcur);
	assign rise      = up_m && up_p;
	assign fall      = !up_m && !up_p;
	assign draw_fail = (req_q != sos_pkg::REQ_PLACE) && rise && !(draw_q < thr_q);
	assign dec_status = bound ? sos_pkg::STAT_BOUND :
		draw_fail ? sos_pkg::STAT_DRAW : sos_pkg::STAT_ACCEPTED;
	assign commit  = (state_q == sos_pkg::S_DEC) && (dec_status == sos_pkg::STAT_ACCEPTED);
	assign h_new   = inc ? h_q + 1'b1 : h_q - 1'b1;
	assign en_next = rise ? en_q + EW'(2) :
		fall ? ((en_q < EW'(2)) ? '0 : en_q - EW'(2)) : en_q;

	assign shift_more = shift_rd_q < count_q;
	assign shift_done = (state_q == sos_pkg::S_SHIFT) && !shift_more && !sh_s1;

	// particle list ports
	assign p_we    = (commit && inc) || ((state_q == sos_pkg::S_SHIFT) && sh_s1);
	assign p_waddr = (state_q == sos_pkg::S_SHIFT) ? sh_addr_s1 : count_q[PW-1:0];
	assign p_wdata = (state_q == sos_pkg::S_SHIFT) ? plist_rdata_s1 : col_q;
	assign p_raddr = (state_q == sos_pkg::S_PRD) ? pick_q : shift_rd_q[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sos_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			sos_pkg::S_IDLE: begin
				if (req.valid) begin
					if (req.req_type inside {sos_pkg::REQ_PLACE, sos_pkg::REQ_CREATE}) begin
						state_d = sos_pkg::S_HC;
					end else if (req.req_type == sos_pkg::REQ_DESTROY && pick_ok) begin
						state_d = sos_pkg::S_PRD;
					end else begin
						state_d = sos_pkg::S_FIN;
					end
				end
			end
			sos_pkg::S_PRD: state_d = sos_pkg::S_HC;
			sos_pkg::S_HC:  state_d = sos_pkg::S_HM;
			sos_pkg::S_HM:  state_d = sos_pkg::S_HP;
			sos_pkg::S_HP:  state_d = sos_pkg::S_DEC;
			sos_pkg::S_DEC: begin
				state_d = (commit && !inc) ? sos_pkg::S_SHIFT : sos_pkg::S_FIN;
			end
			sos_pkg::S_SHIFT: begin
				if (shift_done) begin
					state_d = sos_pkg::S_FIN;
				end
			end
			sos_pkg::S_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = sos_pkg::S_IDLE;
				end
			end
			default: state_d = sos_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= sos_pkg::THRESHOLD_RESET;
			maxh_q      <= sos_pkg::MAX_HEIGHT_RESET;
			count_q     <= '0;
			en_q        <= '0;
			hv_q        <= '0;
			sh_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (sos_pkg::cfg_idx_t'(cfg_index))
					sos_pkg::CFG_ACCEPT_THRESHOLD: thr_q  <= cfg_wdata[RW-1:0];
					sos_pkg::CFG_MAX_HEIGHT:       maxh_q <= cfg_wdata[HB-1:0];
					default: ;
				endcase
			end
			if (commit) begin
				en_q          <= en_next;
				hv_q[col_q]   <= 1'b1;
				if (inc) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (state_q == sos_pkg::S_SHIFT) begin
				sh_s1 <= shift_more;
			end
			if (shift_done) begin
				count_q <= count_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req.req_type;
			col_q  <= (req.req_type inside {sos_pkg::REQ_PLACE, sos_pkg::REQ_CREATE}) ?
				req.site : '0;
			pick_q <= req.pick;
			draw_q <= req.random_draw;
			res_status_q <= sos_pkg::STAT_INVALID;
		end
		case (state_q)
			sos_pkg::S_HC:  col_q <= cur_col;
			sos_pkg::S_HM:  h_q   <= hcur;
			sos_pkg::S_HP:  hm_q  <= hcur;
			sos_pkg::S_DEC: begin
				res_status_q <= dec_status;
				shift_rd_q   <= CW'(pick_q) + 1'b1;
			end
			sos_pkg::S_SHIFT: begin
				if (shift_more) begin
					sh_addr_s1 <= shift_rd_q[PW-1:0] - 1'b1;
					shift_rd_q <= shift_rd_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_status_q <= res_status_q;
			out_site_q   <= col_q;
			out_energy_q <= en_q;
			out_count_q  <= count_q[PW-1:0];
		end
	end

	// height RAM
	always_ff @(posedge clk) begin
		h_rdata_s1 <= heights_mem[h_raddr];
		hval_s1    <= hv_q[h_raddr];
		if (commit) begin
			heights_mem[col_q] <= h_new;
		end
	end

	// particle list RAM
	always_ff @(posedge clk) begin
		plist_rdata_s1 <= plist_mem[p_raddr];
		if (p_we) begin
			plist_mem[p_waddr] <= p_wdata;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.acted_site     = out_site_q;
	assign rsp.energy         = out_energy_q;
	assign rsp.particle_count = out_count_q;

	`SOS_ASSERT(a_count_cap, count_q <= CW'(sos_pkg::MAX_PARTICLES), "particle count above capacity")
	`SOS_ASSERT(a_energy_even, !en_q[0], "surface energy must be even on a ring")
	`SOS_ASSERT(a_shift_in_list, !sh_s1 || ({1'b0, sh_addr_s1} < count_q), "erase write past list end")
	`SOS_ASSERT_NEXT(a_accept_busy, accept, state_q != sos_pkg::S_IDLE, "engine idle after request")

endmodule
